// ----- rtl/scsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsf_pkg
// Types and codes shared by the syscall sequence filter.
// ----------------------------------------------------------------------------
package scsf_pkg;

    localparam int CALL_W   = 10;
    localparam int TBL_W    = 60;
    localparam int LEN_W    = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        REQ_CALL   = 3'd0,
        REQ_RETURN = 3'd1,
        REQ_EXIT   = 3'd2,
        REQ_ERROR  = 3'd3,
        REQ_SIGNAL = 3'd4,
        REQ_QUOTA  = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        QUOTA_WALL = 2'd0,
        QUOTA_CPU  = 2'd1,
        QUOTA_MEM  = 2'd2,
        QUOTA_DISK = 2'd3
    } quota_kind_t;

    typedef enum logic [1:0] {
        ACT_CONT = 2'd0,
        ACT_KILL = 2'd1,
        ACT_FINI = 2'd2
    } proc_action_t;

    typedef enum logic [3:0] {
        V_NONE = 4'd0,
        V_OK   = 4'd1,
        V_RF   = 4'd2,
        V_AT   = 4'd3,
        V_IE   = 4'd4,
        V_RT   = 4'd5,
        V_TL   = 4'd6,
        V_ML   = 4'd7,
        V_OL   = 4'd8
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_SEQ   = 2'd0,
        CFG_INIT_LEN   = 2'd1,
        CFG_ALLOW_SET  = 2'd2,
        CFG_ALLOW_CNT  = 2'd3
    } cfg_index_t;

endpackage

// ----- rtl/syscall_sequence_filter.sv -----
`timescale 1ns / 1ps
// Results are registered: an accepted transaction shows its result in the next cycle.
// Throughput: one transaction per cycle while the response side does not stall;
// the single result register and the six parallel allowed-set compares set this figure.
// Reset: asynchronous, active low; clears configuration to zero, enters the
// initial phase at position zero, clears the denied call and the result valid.
// ----------------------------------------------------------------------------
// syscall_sequence_filter
// Checks process events against an initial call sequence and an allowed set.
// ----------------------------------------------------------------------------
module syscall_sequence_filter
    import scsf_pkg::*;
#(
    parameter int TABLE_DEPTH = 6,
    parameter int CALL_BITS   = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TBL_W-1:0]     cfg_data,

    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [2:0]           req_type,
    input  logic [CALL_W-1:0]    call_number,
    input  logic [7:0]           exit_status,
    input  logic [1:0]           quota_kind,

    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [1:0]           action,
    output logic [3:0]           verdict,
    output logic [CALL_W-1:0]    last_denied
);

    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(TABLE_DEPTH);

    logic [TBL_W-1:0]  init_seq_reg;
    logic [LEN_W-1:0]  init_len_reg;
    logic [TBL_W-1:0]  allow_set_reg;
    logic [LEN_W-1:0]  allow_cnt_reg;

    logic              in_init_reg, in_init_next;
    logic [LEN_W-1:0]  seq_pos_reg, seq_pos_next;
    logic [CALL_W-1:0] denied_reg, denied_next;

    logic              rsp_valid_reg;
    proc_action_t      action_reg, action_next;
    verdict_t          verdict_reg, verdict_next;
    logic [CALL_W-1:0] last_denied_reg;

    logic              req_accept;
    logic [CALL_W-1:0] call_m;
    logic [CALL_W-1:0] seq_entry;
    logic [LEN_W-1:0]  len_c;
    logic [LEN_W-1:0]  cnt_c;
    logic              allow_hit;
    logic              call_ok;
    logic              seq_check;

    assign cfg_ready  = 1'b1;
    assign req_stall  = rsp_valid_reg && rsp_stall;
    assign req_accept = req_valid && !req_stall;

    assign call_m = CALL_W'(call_number[CALL_BITS-1:0]);
    assign len_c  = (init_len_reg > DEPTH_L) ? DEPTH_L : init_len_reg;
    assign cnt_c  = (allow_cnt_reg > DEPTH_L) ? DEPTH_L : allow_cnt_reg;
    assign seq_check = in_init_reg && (seq_pos_reg < len_c);

    always_comb
    begin
        seq_entry = '0;
        allow_hit = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (seq_pos_reg == LEN_W'(i))
                seq_entry = CALL_W'(init_seq_reg[i*CALL_BITS +: CALL_BITS]);
            if ((LEN_W'(i) < cnt_c) &&
                (call_m == CALL_W'(allow_set_reg[i*CALL_BITS +: CALL_BITS])))
                allow_hit = 1'b1;
        end
    end

    always_comb
    begin
        in_init_next = in_init_reg;
        seq_pos_next = seq_pos_reg;
        denied_next  = denied_reg;
        action_next  = ACT_KILL;
        verdict_next = V_IE;
        call_ok      = seq_check ? (call_m == seq_entry) : allow_hit;
        case (req_type)
            REQ_CALL:
            begin
                if (call_ok)
                begin
                    action_next  = ACT_CONT;
                    verdict_next = V_NONE;
                    if (seq_check)
                    begin
                        seq_pos_next = seq_pos_reg + LEN_W'(1);
                        if (seq_pos_next >= len_c)
                            in_init_next = 1'b0;
                    end
                end
                else
                begin
                    verdict_next = V_RF;
                    denied_next  = call_m;
                end
            end
            REQ_RETURN:
            begin
                action_next  = ACT_CONT;
                verdict_next = V_NONE;
            end
            REQ_EXIT:
            begin
                action_next  = ACT_FINI;
                verdict_next = (exit_status == 8'd0) ? V_OK : V_AT;
            end
            REQ_SIGNAL:
                verdict_next = V_RT;
            REQ_QUOTA:
            begin
                case (quota_kind)
                    QUOTA_MEM:  verdict_next = V_ML;
                    QUOTA_DISK: verdict_next = V_OL;
                    default:    verdict_next = V_TL;
                endcase
            end
            default:
                verdict_next = V_IE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_seq_reg  <= '0;
            init_len_reg  <= '0;
            allow_set_reg <= '0;
            allow_cnt_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INIT_SEQ:  init_seq_reg  <= cfg_data;
                CFG_INIT_LEN:  init_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_ALLOW_SET: allow_set_reg <= cfg_data;
                CFG_ALLOW_CNT: allow_cnt_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_init_reg   <= 1'b1;
            seq_pos_reg   <= '0;
            denied_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            in_init_reg   <= in_init_next;
            seq_pos_reg   <= seq_pos_next;
            denied_reg    <= denied_next;
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            action_reg      <= action_next;
            verdict_reg     <= verdict_next;
            last_denied_reg <= denied_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign action      = action_reg;
    assign verdict     = verdict_reg;
    assign last_denied = last_denied_reg;

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_pos_reg <= DEPTH_L)
        else $error("sequence position beyond table depth");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(seq_pos_reg) |-> $past(req_accept) &&
            (seq_pos_reg == $past(seq_pos_reg) + LEN_W'(1)))
        else $error("sequence position moved without a single step");

    a_denied_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(denied_reg) |-> $past(req_accept) &&
            ($past(req_type) == REQ_CALL))
        else $error("denied call changed without a call transaction");

    a_phase_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_init_reg) |-> $past(req_accept) && !$stable(seq_pos_reg))
        else $error("initial phase ended without a sequence match");

    a_cont_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (action_reg == ACT_CONT) |-> verdict_reg == V_NONE)
        else $error("continue result carries a verdict");
`endif

endmodule
